/* hdl/rastf_pkg.sv */
// ----------------------------------------------------------------------------
// rastf_pkg
// Shared types, field widths and the elaboration-time cosine math for the
// Rastrigin fitness accumulator.
// ----------------------------------------------------------------------------
package rastf_pkg;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 12;
  localparam int AMP_W     = 8;
  localparam int FIT_W     = 26;
  localparam int DIMS_W    = 7;
  localparam int ENTRY_W   = 14;   // 1 - cos in Q.12, 0 to 8192
  localparam int SQUARE_W  = 19;   // x^2 in Q.12, 0 to 262144
  localparam int TERM_W    = 22;   // square + amplitude * entry

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(10);
  localparam logic [FIT_W-1:0] ACC_MAX   = '1;

  // Q30 constants for building the cosine table
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  // Horner divisors (2n-1)*(2n) in Q30, n = 7 down to 1
  localparam longint HORNER_DIV_7 = 64'sd182 * Q30_ONE;
  localparam longint HORNER_DIV_6 = 64'sd132 * Q30_ONE;
  localparam longint HORNER_DIV_5 = 64'sd90 * Q30_ONE;
  localparam longint HORNER_DIV_4 = 64'sd56 * Q30_ONE;
  localparam longint HORNER_DIV_3 = 64'sd30 * Q30_ONE;
  localparam longint HORNER_DIV_2 = 64'sd12 * Q30_ONE;
  localparam longint HORNER_DIV_1 = 64'sd2 * Q30_ONE;

  // One input item
  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [FIT_W-1:0]  fitness;
    logic [DIMS_W-1:0] dims;
    logic              saturated;
  } out_item_t;

  // cos(u) in Q30 for 0 <= u <= pi/2: eight-term Taylor series, Horner form,
  // truncating divisions, clamped to 0..1. Used at elaboration only.
  function automatic longint rastf_cos_q30(input longint u);
    longint u2;
    longint t;
    u2 = (u * u) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_7;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_6;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_5;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_4;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_3;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_2;
    t  = Q30_ONE - (u2 * t) / HORNER_DIV_1;
    if (t < 0) t = 0;
    if (t > Q30_ONE) t = Q30_ONE;
    return t;
  endfunction

endpackage

/* hdl/rastf_stream_if.sv */
// ----------------------------------------------------------------------------
// rastf_stream_if
// Valid/ready stream channel; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface rastf_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* hdl/rastrigin_fitness_top.sv */
// Path: a coordinate marked last passes the stage 1 registers (cosine table
//   read, square), the stage 2 term register, then the accumulate into the result register.
// Throughput: one coordinate per cycle; input ready drops only while a result
//   sits unclaimed, the next last coordinate waits behind it and stage 1 is full.
// Reset: accumulator, dimension count, clip flag and all valids clear at once;
//   amplitude returns to 10. No clearing pass.
// ----------------------------------------------------------------------------
// rastrigin_fitness_top
// Streams coordinates of a candidate point and accumulates the Rastrigin sum
// x^2 + A*(1 - cos(2*pi*x)) in unsigned Q.12 with saturation.
// ----------------------------------------------------------------------------
module rastrigin_fitness_top
  import rastf_pkg::*;
#(
  parameter int MAX_DIMS        = 64,
  parameter int COS_TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             amp_we_i,
  input  logic [AMP_W-1:0] amp_wdata_i,
  rastf_stream_if.sink     in_i,
  rastf_stream_if.source   out_o
);

  localparam int IDX_W = $clog2(COS_TABLE_DEPTH);
  localparam int CNT_W = $clog2(MAX_DIMS + 1);

  // Cosine table: each entry fixed at elaboration
  logic [ENTRY_W-1:0] cos_rom [COS_TABLE_DEPTH];

  for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_rom
    // fold the angle into 0..pi/2
    localparam longint Kf   = (2 * k > COS_TABLE_DEPTH) ? longint'(COS_TABLE_DEPTH - k)
                                                        : longint'(k);
    localparam bit     Low  = (4 * Kf <= COS_TABLE_DEPTH);
    localparam longint Ang  = Low ? (2 * Kf * PI_Q30) / COS_TABLE_DEPTH
                                  : ((COS_TABLE_DEPTH - 2 * Kf) * PI_Q30) / COS_TABLE_DEPTH;
    localparam longint OneMinusCos = Low ? Q30_ONE - rastf_cos_q30(Ang)
                                         : Q30_ONE + rastf_cos_q30(Ang);
    localparam longint Rounded     = (OneMinusCos + (64'sd1 <<< 17)) >>> 18;
    assign cos_rom[k] = ENTRY_W'(Rounded);
  end

  // Amplitude register
  logic [AMP_W-1:0] amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= AMP_RESET;
    end else if (amp_we_i) begin
      amp_q <= amp_wdata_i;
    end
  end

  // Pipeline flow control
  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_last_q, s2_last_q;
  logic out_free, s2_go, s2_free, s1_go, s1_free, in_xfer;

  assign out_free = !out_v_q || out_o.ready;
  assign s2_go    = s2_v_q && (!s2_last_q || out_free);
  assign s2_free  = !s2_v_q || s2_go;
  assign s1_go    = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s1_go;
  assign in_i.ready = s1_free;
  assign in_xfer  = in_i.valid && s1_free;

  // Stage 1 datapath: magnitude square and table index
  logic [COORD_W-1:0]    raw;
  logic [COORD_W-1:0]    mag;
  logic [2*COORD_W-1:0]  prod;
  logic [31:0]           idx_full;
  logic [IDX_W-1:0]      idx;

  assign raw  = in_i.payload.coord;
  assign mag  = raw[COORD_W-1] ? COORD_W'({1'b1, {COORD_W{1'b0}}} - {1'b0, raw}) : raw;
  assign prod = {{COORD_W{1'b0}}, mag} * {{COORD_W{1'b0}}, mag};
  assign idx_full = ({{(32-FRAC_W){1'b0}}, raw[FRAC_W-1:0]} * 32'(COS_TABLE_DEPTH))
                    >> FRAC_W;
  assign idx  = idx_full[IDX_W-1:0];

  logic [SQUARE_W-1:0] square_q;
  logic [ENTRY_W-1:0]  entry_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      square_q  <= prod[FRAC_W+SQUARE_W-1:FRAC_W];
      entry_q   <= cos_rom[idx];
      s1_last_q <= in_i.payload.last;
    end
  end

  // Stage 2: per-coordinate term
  logic [TERM_W-1:0] cos_term;
  logic [TERM_W-1:0] term_q;

  assign cos_term = {{(TERM_W-AMP_W){1'b0}}, amp_q} * {{(TERM_W-ENTRY_W){1'b0}}, entry_q};

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      term_q    <= TERM_W'(square_q) + cos_term;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: saturating accumulate and dimension count
  logic [FIT_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             clip_q, clip_d;
  logic [FIT_W:0]   sum;

  always_comb begin
    sum = {1'b0, acc_q} + (FIT_W+1)'(term_q);
    if (sum > {1'b0, ACC_MAX}) begin
      acc_d  = ACC_MAX;
      clip_d = 1'b1;
    end else begin
      acc_d  = sum[FIT_W-1:0];
      clip_d = clip_q;
    end
    cnt_d = (cnt_q < CNT_W'(MAX_DIMS)) ? cnt_q + CNT_W'(1) : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      clip_q <= 1'b0;
    end else if (s2_go) begin
      if (s2_last_q) begin
        acc_q  <= '0;
        cnt_q  <= '0;
        clip_q <= 1'b0;
      end else begin
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
        clip_q <= clip_d;
      end
    end
  end

  // Result register
  out_item_t res_q;

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_last_q) begin
      res_q.fitness   <= acc_d;
      res_q.dims      <= DIMS_W'(cnt_d);
      res_q.saturated <= clip_d;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_xfer)    s1_v_q <= 1'b1;
      else if (s1_go) s1_v_q <= 1'b0;
      if (s1_go)      s2_v_q <= 1'b1;
      else if (s2_go) s2_v_q <= 1'b0;
      if (s2_go && s2_last_q) out_v_q <= 1'b1;
      else if (out_o.ready)   out_v_q <= 1'b0;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = res_q;

endmodule

/* hdl/rastf_checker.sv */
// ----------------------------------------------------------------------------
// rastf_checker
// Port-level checks for the Rastrigin fitness accumulator, bound to the top.
// ----------------------------------------------------------------------------
module rastf_checker
  import rastf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [FIT_W-1:0]  out_fitness_i,
  input logic [DIMS_W-1:0] out_dims_i,
  input logic              out_saturated_i
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_fitness_i)
      && $stable(out_dims_i) && $stable(out_saturated_i))
    else $error("result changed while stalled");

  // Only a stalled result may hold off new coordinates
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without output stall");

  // Once clipped, the sum stays at full scale
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_saturated_i |-> out_fitness_i == ACC_MAX)
    else $error("saturated result below full scale");

endmodule

bind rastrigin_fitness_top rastf_checker u_rastf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_fitness_i   (out_o.payload.fitness),
  .out_dims_i      (out_o.payload.dims),
  .out_saturated_i (out_o.payload.saturated)
);
